// ===== rtl/i2cms_pkg.sv =====
// shared types, codes and constants of the i2c master byte sequencer
`timescale 1ns / 1ps

package i2cms_pkg;

    // width of the phase tick counter
    localparam int PHASE_COUNT_BITS = 16;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int CFG_W      = 16;
    localparam logic REG_TICKS_PER_PHASE = 1'b0;
    localparam logic [CFG_W-1:0] TICKS_PER_PHASE_RESET = 16'd1;

    // command codes on the func field
    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_START = 3'd1;
    localparam logic [2:0] FUNC_STOP  = 3'd2;
    localparam logic [2:0] FUNC_WRITE = 3'd3;
    localparam logic [2:0] FUNC_READ  = 3'd4;

    // completion status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BUS_BUSY = 2'd1;
    localparam logic [1:0] STATUS_NACK     = 2'd2;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       sda_sample;
    } t_in_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] rx_byte;
        logic       rejected;
    } t_out_item;

    // class of an accepted transaction
    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_TICK  = 3'd1,
        KIND_START = 3'd2,
        KIND_STOP  = 3'd3,
        KIND_WRITE = 3'd4,
        KIND_READ  = 3'd5
    } t_kind;

    // classified transaction held in the queue
    typedef struct packed {
        t_kind      kind;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       sda_sample;
    } t_cmd;

    // bus sequencer states, one-hot
    typedef enum logic [18:0] {
        ST_IDLE = 19'h00001,
        ST_S0   = 19'h00002,
        ST_S1   = 19'h00004,
        ST_S2   = 19'h00008,
        ST_P0   = 19'h00010,
        ST_P1   = 19'h00020,
        ST_P2   = 19'h00040,
        ST_WA   = 19'h00080,
        ST_WB   = 19'h00100,
        ST_WC   = 19'h00200,
        ST_WD   = 19'h00400,
        ST_WE   = 19'h00800,
        ST_WF   = 19'h01000,
        ST_RA   = 19'h02000,
        ST_RB   = 19'h04000,
        ST_RC   = 19'h08000,
        ST_RD   = 19'h10000,
        ST_RE   = 19'h20000,
        ST_RF   = 19'h40000
    } t_state;

endpackage

// ===== rtl/i2cms_front.sv =====
// front end: classifies incoming transactions by their func code
`timescale 1ns / 1ps

module i2cms_front (
    input  i2cms_pkg::t_in_item i_item,
    output i2cms_pkg::t_cmd     o_cmd
);

    i2cms_pkg::t_kind kind;

    always_comb begin
        unique case (i_item.func)
            i2cms_pkg::FUNC_TICK:  kind = i2cms_pkg::KIND_TICK;
            i2cms_pkg::FUNC_START: kind = i2cms_pkg::KIND_START;
            i2cms_pkg::FUNC_STOP:  kind = i2cms_pkg::KIND_STOP;
            i2cms_pkg::FUNC_WRITE: kind = i2cms_pkg::KIND_WRITE;
            i2cms_pkg::FUNC_READ:  kind = i2cms_pkg::KIND_READ;
            default:               kind = i2cms_pkg::KIND_NONE;
        endcase
    end

    assign o_cmd.kind       = kind;
    assign o_cmd.tx_byte    = i_item.tx_byte;
    assign o_cmd.send_nack  = i_item.send_nack;
    assign o_cmd.sda_sample = i_item.sda_sample;

endmodule

// ===== rtl/i2cms_queue.sv =====
// two-entry queue between the classifier and the bus sequencer
`timescale 1ns / 1ps

module i2cms_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  i2cms_pkg::t_cmd     i_data,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output i2cms_pkg::t_cmd     o_data
);

    i2cms_pkg::t_cmd r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = r_count[1];
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/i2cms_engine.sv =====
// back end: bus phase sequencer with registered result
`timescale 1ns / 1ps

module i2cms_engine (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [i2cms_pkg::CFG_W-1:0]  i_ticks_per_phase,
    input  logic                         i_cmd_valid,
    input  i2cms_pkg::t_cmd              i_cmd,
    output logic                         o_cmd_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output i2cms_pkg::t_out_item         o_out_item
);

    localparam int PCB = i2cms_pkg::PHASE_COUNT_BITS;
    localparam logic [32:0] PHASE_MAX = (33'd1 << PCB) - 33'd1;

    i2cms_pkg::t_state r_state, n_state;
    logic [PCB-1:0]    r_tick, n_tick;
    logic [3:0]        r_bits, n_bits;
    logic [7:0]        r_shift, n_shift;
    logic              r_scl, n_scl;
    logic              r_sda, n_sda;
    logic              r_nack, n_nack;
    logic [7:0]        r_last_rx, n_last_rx;

    logic                 r_out_valid;
    i2cms_pkg::t_out_item r_out;

    logic            pop;
    logic            busy;
    logic            done;
    logic [1:0]      stat;
    logic            rej;
    logic [31:0]     len_wide;
    logic [PCB-1:0]  phase_len;
    logic [PCB-1:0]  tick_inc;
    logic [3:0]      bits_inc;

    // zero means one tick, too large saturates to the counter range
    always_comb begin
        len_wide = {{(32 - i2cms_pkg::CFG_W){1'b0}}, i_ticks_per_phase};
        if (len_wide == 32'd0) begin
            len_wide = 32'd1;
        end
        if ({1'b0, len_wide} > PHASE_MAX) begin
            phase_len = PHASE_MAX[PCB-1:0];
        end else begin
            phase_len = len_wide[PCB-1:0];
        end
    end

    assign pop       = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_cmd_pop = pop;
    assign busy      = (r_state != i2cms_pkg::ST_IDLE);
    assign tick_inc  = r_tick + {{(PCB-1){1'b0}}, 1'b1};
    assign bits_inc  = r_bits + 4'd1;

    always_comb begin
        n_state   = r_state;
        n_tick    = r_tick;
        n_bits    = r_bits;
        n_shift   = r_shift;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_nack    = r_nack;
        n_last_rx = r_last_rx;
        done      = 1'b0;
        stat      = i2cms_pkg::STATUS_OK;
        rej       = 1'b0;

        unique case (i_cmd.kind)
            i2cms_pkg::KIND_START,
            i2cms_pkg::KIND_STOP,
            i2cms_pkg::KIND_WRITE,
            i2cms_pkg::KIND_READ: begin
                if (busy) begin
                    rej = 1'b1;
                end else begin
                    n_tick = '0;
                    n_bits = 4'd0;
                    unique case (i_cmd.kind)
                        i2cms_pkg::KIND_START: begin
                            n_sda   = 1'b1;
                            n_scl   = 1'b1;
                            n_state = i2cms_pkg::ST_S0;
                        end
                        i2cms_pkg::KIND_STOP: begin
                            n_sda   = 1'b0;
                            n_state = i2cms_pkg::ST_P0;
                        end
                        i2cms_pkg::KIND_WRITE: begin
                            n_shift = i_cmd.tx_byte;
                            n_sda   = i_cmd.tx_byte[7];
                            n_state = i2cms_pkg::ST_WA;
                        end
                        default: begin
                            n_shift = 8'd0;
                            n_nack  = i_cmd.send_nack;
                            n_sda   = 1'b1;
                            n_state = i2cms_pkg::ST_RA;
                        end
                    endcase
                end
            end
            i2cms_pkg::KIND_TICK: begin
                if (busy) begin
                    if (tick_inc >= phase_len) begin
                        n_tick = '0;
                        unique case (r_state)
                            i2cms_pkg::ST_S0: begin
                                if (!i_cmd.sda_sample) begin
                                    done = 1'b1;
                                    stat = i2cms_pkg::STATUS_BUS_BUSY;
                                end else begin
                                    n_sda   = 1'b0;
                                    n_state = i2cms_pkg::ST_S1;
                                end
                            end
                            i2cms_pkg::ST_S1: begin
                                n_scl   = 1'b0;
                                n_state = i2cms_pkg::ST_S2;
                            end
                            i2cms_pkg::ST_P0: begin
                                n_scl   = 1'b1;
                                n_state = i2cms_pkg::ST_P1;
                            end
                            i2cms_pkg::ST_P1: begin
                                n_sda   = 1'b1;
                                n_state = i2cms_pkg::ST_P2;
                            end
                            i2cms_pkg::ST_WA, i2cms_pkg::ST_WD,
                            i2cms_pkg::ST_RA, i2cms_pkg::ST_RD: begin
                                n_scl = 1'b1;
                                unique case (r_state)
                                    i2cms_pkg::ST_WA: n_state = i2cms_pkg::ST_WB;
                                    i2cms_pkg::ST_WD: n_state = i2cms_pkg::ST_WE;
                                    i2cms_pkg::ST_RA: n_state = i2cms_pkg::ST_RB;
                                    default:          n_state = i2cms_pkg::ST_RE;
                                endcase
                            end
                            i2cms_pkg::ST_WB: begin
                                n_scl   = 1'b0;
                                n_state = i2cms_pkg::ST_WC;
                            end
                            i2cms_pkg::ST_WC: begin
                                n_bits = bits_inc;
                                if (bits_inc < i2cms_pkg::BITS_PER_BYTE) begin
                                    n_shift = {r_shift[6:0], 1'b0};
                                    n_sda   = r_shift[6];
                                    n_state = i2cms_pkg::ST_WA;
                                end else begin
                                    n_sda   = 1'b1;
                                    n_state = i2cms_pkg::ST_WD;
                                end
                            end
                            i2cms_pkg::ST_WE: begin
                                n_nack  = i_cmd.sda_sample;
                                n_scl   = 1'b0;
                                n_state = i2cms_pkg::ST_WF;
                            end
                            i2cms_pkg::ST_WF: begin
                                done = 1'b1;
                                stat = r_nack ? i2cms_pkg::STATUS_NACK
                                              : i2cms_pkg::STATUS_OK;
                            end
                            i2cms_pkg::ST_RB: begin
                                n_shift = {r_shift[6:0], i_cmd.sda_sample};
                                n_bits  = bits_inc;
                                n_scl   = 1'b0;
                                n_state = i2cms_pkg::ST_RC;
                            end
                            i2cms_pkg::ST_RC: begin
                                if (r_bits < i2cms_pkg::BITS_PER_BYTE) begin
                                    n_state = i2cms_pkg::ST_RA;
                                end else begin
                                    n_sda   = r_nack;
                                    n_state = i2cms_pkg::ST_RD;
                                end
                            end
                            i2cms_pkg::ST_RE: begin
                                n_scl   = 1'b0;
                                n_state = i2cms_pkg::ST_RF;
                            end
                            i2cms_pkg::ST_RF: begin
                                n_sda     = 1'b1;
                                n_last_rx = r_shift;
                                done      = 1'b1;
                            end
                            default: begin
                                // end of start or stop hold phase
                                done = 1'b1;
                            end
                        endcase
                        if (done) begin
                            n_state = i2cms_pkg::ST_IDLE;
                        end
                    end else begin
                        n_tick = tick_inc;
                    end
                end
            end
            default: begin
                // unknown func codes pass without effect
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= i2cms_pkg::ST_IDLE;
            r_tick      <= '0;
            r_bits      <= 4'd0;
            r_shift     <= 8'd0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_nack      <= 1'b0;
            r_last_rx   <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_state     <= n_state;
                r_tick      <= n_tick;
                r_bits      <= n_bits;
                r_shift     <= n_shift;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_nack      <= n_nack;
                r_last_rx   <= n_last_rx;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out.scl_level <= n_scl;
            r_out.sda_level <= n_sda;
            r_out.busy_res  <= (n_state != i2cms_pkg::ST_IDLE);
            r_out.done_res  <= done;
            r_out.status    <= done ? stat : i2cms_pkg::STATUS_OK;
            r_out.rx_byte   <= n_last_rx;
            r_out.rejected  <= rej;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== rtl/i2c_master_byte_sequencer.sv =====
// top level of the i2c master byte sequencer: config register, front, queue, sequencer
`timescale 1ns / 1ps

//  channel   handshake                 payload
//  in        i_in_valid / o_in_ready   i_in_item  (func, tx_byte, send_nack, sda_sample)
//  out       o_out_valid / i_out_ready o_out_item (line levels, busy, done, status, rx, rej)
//  config    psel/penable/pwrite/pready paddr, pwdata, prdata (ticks_per_phase at 0x0)
//
// one transaction per clock while the output is not stalled; input is written into the queue at
// the accept edge, and the sequencer and result register load when the sequencer pops that entry
// the rate is set by the sequencer update, one queue entry per clock unless the output stalls
// synchronous active-low reset: both lines released, sequencer idle, queue empty
// a stalled output holds the result register; the two-entry queue keeps taking
// input until it fills, then o_in_ready drops

module i2c_master_byte_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input transactions
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  i2cms_pkg::t_in_item                 i_in_item,
    // result transactions
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output i2cms_pkg::t_out_item                o_out_item,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [i2cms_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [i2cms_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [i2cms_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    logic [i2cms_pkg::CFG_W-1:0] r_ticks_per_phase;
    logic                        reg_idx;
    logic                        cfg_wr;

    i2cms_pkg::t_cmd front_cmd;
    i2cms_pkg::t_cmd q_cmd;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    logic            in_acc;

    // register index sits above the byte-in-word bits
    assign reg_idx = paddr[i2cms_pkg::APB_ADDR_W-1];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_phase <= i2cms_pkg::TICKS_PER_PHASE_RESET;
        end else if (cfg_wr && (reg_idx == i2cms_pkg::REG_TICKS_PER_PHASE)) begin
            r_ticks_per_phase <= pwdata[i2cms_pkg::CFG_W-1:0];
        end
    end

    // writes beyond the one register are dropped and read back as zero
    always_comb begin
        if (reg_idx == i2cms_pkg::REG_TICKS_PER_PHASE) begin
            prdata = {{(i2cms_pkg::APB_DATA_W - i2cms_pkg::CFG_W){1'b0}},
                      r_ticks_per_phase};
        end else begin
            prdata = '0;
        end
    end

    // front: decode func into a transaction class
    i2cms_front u_front (
        .i_item (i_in_item),
        .o_cmd  (front_cmd)
    );

    assign o_in_ready = !q_full;
    assign in_acc     = i_in_valid && !q_full;

    // decoupling queue, lets the bus side stall on its own
    i2cms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_acc),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    // back: bus phase sequencer and result register
    i2cms_engine u_engine (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ticks_per_phase (r_ticks_per_phase),
        .i_cmd_valid       (q_valid),
        .i_cmd             (q_cmd),
        .o_cmd_pop         (q_pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_item        (o_out_item)
    );

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for the i2c master byte sequencer
`timescale 1ns / 1ps

module testbench;

    // run length guard, far above the slowest legal run
    localparam int CYCLE_LIMIT = 600000;
    // random stimulus items per phase-length setting
    localparam int RANDOM_PER_PHASE = 180;
    localparam int MAX_GAP = 6;
    // ticks spent inside one long phase before the length is cut back
    localparam int LONG_TICKS = 40;

    localparam logic [i2cms_pkg::APB_ADDR_W-1:0] TPP_ADDR =
        {i2cms_pkg::REG_TICKS_PER_PHASE, 2'b00};
    localparam logic [i2cms_pkg::CFG_W-1:0] TPP_MAX = 16'hFFFF;

    // func codes with no command behind them
    localparam logic [2:0] FUNC_RSVD_5 = 3'd5;
    localparam logic [2:0] FUNC_RSVD_6 = 3'd6;
    localparam logic [2:0] FUNC_RSVD_7 = 3'd7;

    // delay phases taken by each command when nothing ends it early
    localparam int START_PHASES = 3;
    localparam int STOP_PHASES  = 3;
    localparam int BYTE_PHASES  = 27;

    // results that can be read straight off the bus rules
    localparam i2cms_pkg::t_out_item RES_IDLE =
        {1'b1, 1'b1, 1'b0, 1'b0, i2cms_pkg::STATUS_OK, 8'h00, 1'b0};
    localparam i2cms_pkg::t_out_item RES_REJECT =
        {1'b1, 1'b1, 1'b1, 1'b0, i2cms_pkg::STATUS_OK, 8'h00, 1'b1};
    localparam i2cms_pkg::t_out_item RES_BUS_BUSY =
        {1'b1, 1'b1, 1'b0, 1'b1, i2cms_pkg::STATUS_BUS_BUSY, 8'h00, 1'b0};

    // one line of the directed table
    typedef struct packed {
        i2cms_pkg::t_in_item  item;
        logic [7:0]           reps;
        logic                 typed;
        i2cms_pkg::t_out_item want;
    } t_dir_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_in_valid;
    logic                             o_in_ready;
    i2cms_pkg::t_in_item              i_in_item;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b1;
    i2cms_pkg::t_out_item             o_out_item;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [i2cms_pkg::APB_ADDR_W-1:0] paddr;
    logic [i2cms_pkg::APB_DATA_W-1:0] pwdata;
    logic [i2cms_pkg::APB_DATA_W-1:0] prdata;
    logic                             pready;

    // fixed expectation riding along with the transaction being offered
    logic                 due_typed;
    i2cms_pkg::t_out_item due_fixed;

    // no idling on either side while set
    bit calm;

    // bus model state, own copy of the register included
    logic [i2cms_pkg::CFG_W-1:0] cfg_tpp;
    i2cms_pkg::t_state           seq_st;
    logic [3:0]                  bit_cnt;
    logic [7:0]                  shreg;
    logic                        scl_q;
    logic                        sda_q;
    logic [15:0]                 tick_cnt;
    logic                        ack_bit;
    logic [7:0]                  rx_last;

    // predicted results in order of the transactions that caused them
    i2cms_pkg::t_out_item bus_results_due [$];

    int fails;
    int n_results;
    int n_done;
    int n_bus_busy;
    int n_nack;
    int n_rejected;
    int stall_left;

    i2c_master_byte_sequencer dut (
        .i_clk,
        .i_rst_n,
        .i_in_valid,
        .o_in_ready,
        .i_in_item,
        .o_out_valid,
        .i_out_ready,
        .o_out_item,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop if the run hangs
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("i2c_master_byte_sequencer: mismatch");
        $finish;
    end

    function automatic i2cms_pkg::t_in_item mk_in(logic [2:0] f, logic [7:0] tx, logic nk,
                                                  logic s);
        return {f, tx, nk, s};
    endfunction

    function automatic t_dir_row dir_row(i2cms_pkg::t_in_item it, int reps, logic typed,
                                         i2cms_pkg::t_out_item want);
        return {it, 8'(reps), typed, want};
    endfunction

    // bus model: advance by one transaction and return the result it shows
    function automatic i2cms_pkg::t_out_item next_bus_result(i2cms_pkg::t_in_item it);
        i2cms_pkg::t_out_item        r;
        logic                        busy;
        logic                        done;
        logic                        rej;
        logic [1:0]                  stat;
        logic [i2cms_pkg::CFG_W-1:0] plen;
        busy = (seq_st != i2cms_pkg::ST_IDLE);
        done = 1'b0;
        rej  = 1'b0;
        stat = i2cms_pkg::STATUS_OK;
        // a zero length still means one tick per phase
        plen = (cfg_tpp == '0) ? i2cms_pkg::CFG_W'(1) : cfg_tpp;
        if (it.func >= i2cms_pkg::FUNC_START && it.func <= i2cms_pkg::FUNC_READ) begin
            if (busy) begin
                // command on top of a running one is dropped
                rej = 1'b1;
            end else begin
                tick_cnt = '0;
                bit_cnt  = '0;
                case (it.func)
                    i2cms_pkg::FUNC_START: begin
                        // releases both lines, also as a repeated start
                        sda_q  = 1'b1;
                        scl_q  = 1'b1;
                        seq_st = i2cms_pkg::ST_S0;
                    end
                    i2cms_pkg::FUNC_STOP: begin
                        sda_q  = 1'b0;
                        seq_st = i2cms_pkg::ST_P0;
                    end
                    i2cms_pkg::FUNC_WRITE: begin
                        shreg  = it.tx_byte;
                        sda_q  = it.tx_byte[7];
                        seq_st = i2cms_pkg::ST_WA;
                    end
                    default: begin
                        shreg   = '0;
                        ack_bit = it.send_nack;
                        sda_q   = 1'b1;
                        seq_st  = i2cms_pkg::ST_RA;
                    end
                endcase
            end
        end else if (it.func == i2cms_pkg::FUNC_TICK && busy) begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= plen) begin
                // end of a delay phase, sample taken from this tick
                tick_cnt = '0;
                case (seq_st)
                    i2cms_pkg::ST_S0: begin
                        if (!it.sda_sample) begin
                            // someone else holds sda low
                            done = 1'b1;
                            stat = i2cms_pkg::STATUS_BUS_BUSY;
                        end else begin
                            sda_q  = 1'b0;
                            seq_st = i2cms_pkg::ST_S1;
                        end
                    end
                    i2cms_pkg::ST_S1: begin scl_q = 1'b0; seq_st = i2cms_pkg::ST_S2; end
                    i2cms_pkg::ST_S2: done = 1'b1;
                    i2cms_pkg::ST_P0: begin scl_q = 1'b1; seq_st = i2cms_pkg::ST_P1; end
                    i2cms_pkg::ST_P1: begin sda_q = 1'b1; seq_st = i2cms_pkg::ST_P2; end
                    i2cms_pkg::ST_P2: done = 1'b1;
                    i2cms_pkg::ST_WA: begin scl_q = 1'b1; seq_st = i2cms_pkg::ST_WB; end
                    i2cms_pkg::ST_WB: begin scl_q = 1'b0; seq_st = i2cms_pkg::ST_WC; end
                    i2cms_pkg::ST_WC: begin
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt < i2cms_pkg::BITS_PER_BYTE) begin
                            shreg  = {shreg[6:0], 1'b0};
                            sda_q  = shreg[7];
                            seq_st = i2cms_pkg::ST_WA;
                        end else begin
                            // release sda for the slave ack
                            sda_q  = 1'b1;
                            seq_st = i2cms_pkg::ST_WD;
                        end
                    end
                    i2cms_pkg::ST_WD: begin scl_q = 1'b1; seq_st = i2cms_pkg::ST_WE; end
                    i2cms_pkg::ST_WE: begin
                        ack_bit = it.sda_sample;
                        scl_q   = 1'b0;
                        seq_st  = i2cms_pkg::ST_WF;
                    end
                    i2cms_pkg::ST_WF: begin
                        done = 1'b1;
                        stat = ack_bit ? i2cms_pkg::STATUS_NACK : i2cms_pkg::STATUS_OK;
                    end
                    i2cms_pkg::ST_RA: begin scl_q = 1'b1; seq_st = i2cms_pkg::ST_RB; end
                    i2cms_pkg::ST_RB: begin
                        shreg   = {shreg[6:0], it.sda_sample};
                        bit_cnt = bit_cnt + 4'd1;
                        scl_q   = 1'b0;
                        seq_st  = i2cms_pkg::ST_RC;
                    end
                    i2cms_pkg::ST_RC: begin
                        if (bit_cnt < i2cms_pkg::BITS_PER_BYTE) begin
                            seq_st = i2cms_pkg::ST_RA;
                        end else begin
                            sda_q  = ack_bit;
                            seq_st = i2cms_pkg::ST_RD;
                        end
                    end
                    i2cms_pkg::ST_RD: begin scl_q = 1'b1; seq_st = i2cms_pkg::ST_RE; end
                    i2cms_pkg::ST_RE: begin scl_q = 1'b0; seq_st = i2cms_pkg::ST_RF; end
                    i2cms_pkg::ST_RF: begin
                        sda_q   = 1'b1;
                        rx_last = shreg;
                        done    = 1'b1;
                    end
                    default: done = 1'b1;
                endcase
                if (done) begin
                    seq_st = i2cms_pkg::ST_IDLE;
                end
            end
        end
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.busy_res  = (seq_st != i2cms_pkg::ST_IDLE);
        r.done_res  = done;
        r.status    = done ? stat : i2cms_pkg::STATUS_OK;
        r.rx_byte   = rx_last;
        r.rejected  = rej;
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s expected %0h got %0h", name, want, got);
            fails++;
        end
    endtask

    // compare every result transaction, then log the new input transaction
    always @(posedge i_clk) begin : scoreboard
        i2cms_pkg::t_out_item want;
        if (!i_rst_n) begin
            cfg_tpp  = i2cms_pkg::TICKS_PER_PHASE_RESET;
            seq_st   = i2cms_pkg::ST_IDLE;
            bit_cnt  = '0;
            shreg    = '0;
            scl_q    = 1'b1;
            sda_q    = 1'b1;
            tick_cnt = '0;
            ack_bit  = 1'b0;
            rx_last  = '0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == TPP_ADDR) begin
                cfg_tpp = pwdata[i2cms_pkg::CFG_W-1:0];
            end
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (bus_results_due.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    fails++;
                end else begin
                    want = bus_results_due.pop_front();
                    check_field("scl_level", want.scl_level, o_out_item.scl_level);
                    check_field("sda_level", want.sda_level, o_out_item.sda_level);
                    check_field("busy_res", want.busy_res, o_out_item.busy_res);
                    check_field("done_res", want.done_res, o_out_item.done_res);
                    check_field("status", want.status, o_out_item.status);
                    check_field("rx_byte", want.rx_byte, o_out_item.rx_byte);
                    check_field("rejected", want.rejected, o_out_item.rejected);
                end
                if (o_out_item.done_res) n_done++;
                if (o_out_item.done_res && o_out_item.status == i2cms_pkg::STATUS_BUS_BUSY)
                    n_bus_busy++;
                if (o_out_item.done_res && o_out_item.status == i2cms_pkg::STATUS_NACK)
                    n_nack++;
                if (o_out_item.rejected) n_rejected++;
            end
            if (i_in_valid && o_in_ready) begin
                want = next_bus_result(i_in_item);
                bus_results_due.push_back(due_typed ? due_fixed : want);
            end
        end
    end

    // receiver pacing: random stall after each result transaction
    always @(posedge i_clk) begin : out_pacing
        int gap;
        if (i_out_ready && o_out_valid) begin
            gap = calm ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                stall_left  <= gap;
            end
        end else if (!i_out_ready) begin
            if (stall_left <= 1) i_out_ready <= 1'b1;
            stall_left <= stall_left - 1;
        end
    end

    // offer one input transaction after a random gap and hold it until taken;
    // valid stays high across back-to-back transactions
    task automatic send_item(i2cms_pkg::t_in_item it, logic typed,
                             i2cms_pkg::t_out_item want);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        due_typed  <= typed;
        due_fixed  <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // stop sending and wait for every outstanding result, plus a tail
    task automatic settle(int extra);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (bus_results_due.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    // apb write of the phase length, setup then access phase, upper data bits random
    task automatic apb_write(logic [i2cms_pkg::CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TPP_ADDR;
        pwdata  <= {16'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // mostly whole commands followed by the ticks they need, with noise
    // transactions, commands on a busy bus and full drains mixed in
    task automatic run_random(int target);
        int                  count;
        int                  pick;
        int                  phases;
        int                  plen;
        int                  k;
        logic [2:0]          cmd;
        i2cms_pkg::t_in_item it;
        count = 0;
        while (count < target) begin
            pick = $urandom_range(0, 99);
            plen = (cfg_tpp == '0) ? 1 : int'(cfg_tpp);
            if (pick < 8) begin
                it = mk_in(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                           1'($urandom));
                send_item(it, 1'b0, RES_IDLE);
                if (it.func <= i2cms_pkg::FUNC_READ) count++;
            end else if (pick < 10) begin
                // sender holds off until the pipeline is empty
                settle(0);
            end else begin
                cmd = 3'($urandom_range(i2cms_pkg::FUNC_START, i2cms_pkg::FUNC_READ));
                send_item(mk_in(cmd, 8'($urandom), 1'($urandom), 1'($urandom)), 1'b0,
                          RES_IDLE);
                count++;
                if (cmd == i2cms_pkg::FUNC_START) phases = START_PHASES;
                else if (cmd == i2cms_pkg::FUNC_STOP) phases = STOP_PHASES;
                else phases = BYTE_PHASES;
                k = 0;
                while (k < phases * plen) begin
                    if ($urandom_range(0, 99) < 4) begin
                        // command while busy, rejected unless a start has already ended early
                        it = mk_in(3'($urandom_range(i2cms_pkg::FUNC_START,
                                                     i2cms_pkg::FUNC_READ)),
                                   8'($urandom), 1'($urandom), 1'($urandom));
                    end else begin
                        // starts mostly see a free bus
                        it = mk_in(i2cms_pkg::FUNC_TICK, 8'($urandom), 1'($urandom),
                                   (cmd == i2cms_pkg::FUNC_START)
                                       ? 1'($urandom_range(0, 3) != 0)
                                       : 1'($urandom));
                        k++;
                    end
                    send_item(it, 1'b0, RES_IDLE);
                    count++;
                end
            end
        end
    endtask

    initial begin : stimulus
        t_dir_row rows [25];
        int       plan_tpp [7];
        int       tpp;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        due_typed   <= 1'b0;
        due_fixed   <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        i_rst_n     <= 1'b0;
        calm        = 1'b0;

        // directed table, phase length left at its reset value
        rows[0]  = dir_row(mk_in(i2cms_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b0), 1, 1'b1,
                           RES_IDLE);
        rows[1]  = dir_row(mk_in(FUNC_RSVD_5, 8'hFF, 1'b1, 1'b1), 1, 1'b1, RES_IDLE);
        rows[2]  = dir_row(mk_in(FUNC_RSVD_6, 8'h00, 1'b0, 1'b0), 1, 1'b1, RES_IDLE);
        rows[3]  = dir_row(mk_in(FUNC_RSVD_7, 8'hFF, 1'b1, 1'b1), 1, 1'b1, RES_IDLE);
        rows[4]  = dir_row(mk_in(i2cms_pkg::FUNC_START, 8'h00, 1'b0, 1'b1), 1, 1'b0,
                           RES_IDLE);
        rows[5]  = dir_row(mk_in(i2cms_pkg::FUNC_WRITE, 8'hFF, 1'b0, 1'b0), 1, 1'b1,
                           RES_REJECT);
        rows[6]  = dir_row(mk_in(i2cms_pkg::FUNC_READ, 8'h00, 1'b1, 1'b1), 1, 1'b1,
                           RES_REJECT);
        rows[7]  = dir_row(mk_in(i2cms_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b1), START_PHASES,
                           1'b0, RES_IDLE);
        // all-zero byte, slave acks
        rows[8]  = dir_row(mk_in(i2cms_pkg::FUNC_WRITE, 8'h00, 1'b0, 1'b0), 1, 1'b0,
                           RES_IDLE);
        rows[9]  = dir_row(mk_in(i2cms_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b0), BYTE_PHASES,
                           1'b0, RES_IDLE);
        // all-ones byte, slave nacks
        rows[10] = dir_row(mk_in(i2cms_pkg::FUNC_WRITE, 8'hFF, 1'b0, 1'b0), 1, 1'b0,
                           RES_IDLE);
        rows[11] = dir_row(mk_in(i2cms_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b1), BYTE_PHASES,
                           1'b0, RES_IDLE);
        // read all ones, master nacks
        rows[12] = dir_row(mk_in(i2cms_pkg::FUNC_READ, 8'h00, 1'b1, 1'b0), 1, 1'b0,
                           RES_IDLE);
        rows[13] = dir_row(mk_in(i2cms_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b1), BYTE_PHASES,
                           1'b0, RES_IDLE);
        // repeated start right after a read
        rows[14] = dir_row(mk_in(i2cms_pkg::FUNC_START, 8'h00, 1'b0, 1'b1), 1, 1'b0,
                           RES_IDLE);
        rows[15] = dir_row(mk_in(i2cms_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b1), START_PHASES,
                           1'b0, RES_IDLE);
        // read all zeros, master acks
        rows[16] = dir_row(mk_in(i2cms_pkg::FUNC_READ, 8'hFF, 1'b0, 1'b1), 1, 1'b0,
                           RES_IDLE);
        rows[17] = dir_row(mk_in(i2cms_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b0), BYTE_PHASES,
                           1'b0, RES_IDLE);
        rows[18] = dir_row(mk_in(i2cms_pkg::FUNC_STOP, 8'h00, 1'b0, 1'b1), 1, 1'b0,
                           RES_IDLE);
        rows[19] = dir_row(mk_in(i2cms_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b1), STOP_PHASES,
                           1'b0, RES_IDLE);
        // stop on an already released bus
        rows[20] = dir_row(mk_in(i2cms_pkg::FUNC_STOP, 8'h00, 1'b0, 1'b0), 1, 1'b0,
                           RES_IDLE);
        rows[21] = dir_row(mk_in(i2cms_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b0), STOP_PHASES,
                           1'b0, RES_IDLE);
        // sda held low by another master ends the start
        rows[22] = dir_row(mk_in(i2cms_pkg::FUNC_START, 8'h00, 1'b0, 1'b1), 1, 1'b0,
                           RES_IDLE);
        rows[23] = dir_row(mk_in(i2cms_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b0), 1, 1'b1,
                           RES_BUS_BUSY);
        rows[24] = dir_row(mk_in(i2cms_pkg::FUNC_TICK, 8'hFF, 1'b1, 1'b1), 1, 1'b1,
                           RES_IDLE);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r]) begin
            repeat (rows[r].reps) send_item(rows[r].item, rows[r].typed, rows[r].want);
        end
        settle(4);

        // longest phase: ticks inside a start phase, then the length cut back mid-command
        calm = 1'b1;
        apb_write(TPP_MAX);
        send_item(mk_in(i2cms_pkg::FUNC_START, 8'($urandom), 1'($urandom), 1'($urandom)),
                  1'b0, RES_IDLE);
        for (int k = 0; k < LONG_TICKS; k++) begin
            send_item(mk_in(i2cms_pkg::FUNC_TICK, 8'($urandom), 1'($urandom), 1'($urandom)),
                      1'b0, RES_IDLE);
        end
        settle(4);
        apb_write(i2cms_pkg::CFG_W'(1));
        repeat (2) send_item(mk_in(i2cms_pkg::FUNC_TICK, 8'h00, 1'b0, 1'b1), 1'b0,
                             RES_IDLE);
        settle(4);

        // random part over several phase lengths, zero included; negative means random
        plan_tpp = '{0, 2, 1, 3, -1, 1, 4};
        foreach (plan_tpp[p]) begin
            tpp  = (plan_tpp[p] < 0) ? $urandom_range(1, 4) : plan_tpp[p];
            calm = (p == 5);
            apb_write(i2cms_pkg::CFG_W'(tpp));
            run_random(RANDOM_PER_PHASE);
            settle(4);
        end

        $display("checked %0d results: %0d commands done, %0d bus busy, %0d nack, %0d rejected",
                 n_results, n_done, n_bus_busy, n_nack, n_rejected);
        $display("phase lengths zero to %0d, directed table plus random command sequences",
                 TPP_MAX);
        if (fails == 0) begin
            $display("i2c_master_byte_sequencer: match");
        end else begin
            $display("i2c_master_byte_sequencer: mismatch");
        end
        $finish;
    end

endmodule
